// ===== hw/rtl/frm_pkg.sv =====
// frm_pkg: shared types, widths and codes of the frame rate meter
package frm_pkg;

    // ring of uniqueness flags
    localparam int MAX_WINDOW = 256;
    localparam int POS_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = 8;
    localparam int SUM_W      = LEN_W + 1;

    // register widths
    localparam int FPS_W      = 16;
    localparam int PERIOD_W   = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PERIOD_W;

    // counters and results
    localparam int COUNT_W    = 32;
    localparam int DEN_W      = COUNT_W + 1;
    localparam int PROD_W     = COUNT_W + FPS_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int ELAPSED_W  = 63;
    localparam int FT_W       = PERIOD_W + LEN_W;

    // serial multiplier and divider steps
    localparam int STEPS      = 16;
    localparam int STEP_W     = $clog2(STEPS);

    // register reset values
    localparam logic [LEN_W-1:0]    WINDOW_LEN_RST = 8'd60;
    localparam logic [FPS_W-1:0]    FPS_RST        = 16'd15360;
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = 30'd16666667;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEN  = 2'd0,
        REG_RECORDED_FPS = 2'd1,
        REG_FRAME_PERIOD = 2'd2
    } frm_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } frm_state_t;

endpackage

// ===== hw/rtl/frm_if.sv =====
// frm_if: item channels of the frame rate meter (frame flags in, results out)
interface frm_in_if;
    logic valid;
    logic ready;
    logic frame_unique;

    modport source (output valid, output frame_unique, input ready);
    modport sink   (input valid, input frame_unique, output ready);
endinterface

interface frm_out_if;
    logic                                valid;
    logic                                ready;
    logic [frm_pkg::ELAPSED_W-1:0]       elapsed_ns;
    logic [frm_pkg::FPS_W-1:0]           average_fps_q8;
    logic [frm_pkg::FPS_W-1:0]           window_fps_q8;
    logic [frm_pkg::FT_W-1:0]            frametime_ns;
    logic                                is_unique;

    modport source (output valid, output elapsed_ns, output average_fps_q8,
                    output window_fps_q8, output frametime_ns, output is_unique,
                    input ready);
    modport sink   (input valid, input elapsed_ns, input average_fps_q8,
                    input window_fps_q8, input frametime_ns, input is_unique,
                    output ready);
endinterface

// ===== hw/rtl/frame_rate_meter.sv =====
// frame_rate_meter: per-frame elapsed time, average fps, windowed fps and frametime
//
//   channel  | dir | payload                                         | accepted when
//   ---------+-----+-------------------------------------------------+-------------------
//   frame    | in  | frame_unique                                    | valid & ready
//   result   | out | elapsed_ns, average_fps_q8, window_fps_q8,      | valid & ready
//            |     | frametime_ns, is_unique                         |
//   cfg      | in  | cfg_index, cfg_data                             | cfg_we
//
// an item with a result goes from acceptance to the output register through
// one ring read, 16 steps of the shift-add multipliers, a set-up step,
// 16 steps of the restoring dividers and a load step;
// the reference item after reset frees the input once its ring read is done;
// the next item is accepted the cycle after the result is loaded; a result
// waiting in the output register only blocks once the next one is finished
// reset is asynchronous, active low; the flag ring has a valid bit per entry,
// so neither reset nor a window length write needs a clearing pass
module frame_rate_meter (
    input  logic                            clk,
    input  logic                            rst_n,
    frm_in_if.sink                          frame,
    frm_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [frm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [frm_pkg::LEN_W-1:0]      win_len_reg;
    logic [frm_pkg::FPS_W-1:0]      fps_reg;
    logic [frm_pkg::PERIOD_W-1:0]   period_reg;

    // measurement state
    frm_pkg::frm_state_t            state_reg, state_next;
    logic                           primed_reg;
    logic [frm_pkg::SUM_W-1:0]      ring_sum_reg;
    logic [frm_pkg::POS_W-1:0]      ring_pos_reg;
    logic [frm_pkg::LEN_W-1:0]      dupe_run_reg;
    logic [frm_pkg::COUNT_W-1:0]    unique_total_reg;
    logic [frm_pkg::COUNT_W-1:0]    frames_seen_reg;
    logic [frm_pkg::ELAPSED_W-1:0]  time_acc_reg;
    logic [frm_pkg::MAX_WINDOW-1:0] ring_valid_reg;
    logic [frm_pkg::STEP_W-1:0]     step_cnt_reg;
    logic                           out_valid_reg;

    // flag ring memory
    logic                           ring_mem [frm_pkg::MAX_WINDOW];
    logic                           rd_bit_reg;

    // item datapath
    logic                           unique_reg;
    logic                           k_lt_len_reg;
    logic [frm_pkg::DEN_W-1:0]      den_a_reg;
    logic [frm_pkg::DEN_W-1:0]      den_w_reg;
    logic [frm_pkg::PROD_W-1:0]     mul_a_reg;
    logic [frm_pkg::FPS_W-1:0]      mul_b_reg;
    logic [frm_pkg::PROD_W-1:0]     acc_a_reg;
    logic [frm_pkg::FT_W-1:0]       ft_a_reg;
    logic [frm_pkg::LEN_W-1:0]      ft_b_reg;
    logic [frm_pkg::FT_W-1:0]       ft_acc_reg;
    logic [frm_pkg::DEN_W-1:0]      rem_a_reg;
    logic [frm_pkg::DEN_W-1:0]      rem_w_reg;
    logic [frm_pkg::FPS_W-1:0]      low_a_reg;
    logic [frm_pkg::FPS_W-1:0]      low_w_reg;
    logic [frm_pkg::FPS_W-1:0]      q_a_reg;
    logic [frm_pkg::FPS_W-1:0]      q_w_reg;
    logic                           sat_a_reg;
    logic                           sat_w_reg;

    // output register
    logic [frm_pkg::ELAPSED_W-1:0]  elapsed_reg;
    logic [frm_pkg::FPS_W-1:0]      avg_fps_reg;
    logic [frm_pkg::FPS_W-1:0]      win_fps_reg;
    logic [frm_pkg::FT_W-1:0]       frametime_reg;
    logic                           is_unique_reg;

    // combinational signals
    logic                           frame_ready;
    logic                           accept;
    logic                           load_out;
    logic                           step_last;
    logic [frm_pkg::LEN_W-1:0]      eff_len;
    logic [frm_pkg::POS_W-1:0]      pos_eff;
    logic [frm_pkg::POS_W-1:0]      pos_plus;
    logic [frm_pkg::POS_W-1:0]      pos_next;
    logic                           wr_bit;
    logic                           old_bit;
    logic [frm_pkg::SUM_W-1:0]      sum_next;
    logic [frm_pkg::ELAPSED_W:0]    time_sum;
    logic [frm_pkg::ELAPSED_W-1:0]  time_next;
    logic [frm_pkg::COUNT_W-1:0]    unique_next;
    logic [frm_pkg::COUNT_W-1:0]    frames_next;
    logic [frm_pkg::LEN_W-1:0]      len_m1;
    logic [frm_pkg::LEN_W-1:0]      run;
    logic [frm_pkg::LEN_W-1:0]      run_plus;
    logic [frm_pkg::NUM_W-1:0]      num_a;
    logic [frm_pkg::NUM_W-1:0]      num_w;
    logic [frm_pkg::FT_W-frm_pkg::PERIOD_W+frm_pkg::SUM_W-1:0] win_prod;
    logic [frm_pkg::FT_W-frm_pkg::PERIOD_W+frm_pkg::SUM_W-1:0] win_base;
    logic [frm_pkg::DEN_W-1:0]      den_w;
    logic [frm_pkg::DEN_W:0]        r2_a;
    logic [frm_pkg::DEN_W:0]        r2_w;
    logic [frm_pkg::DEN_W:0]        diff_a;
    logic [frm_pkg::DEN_W:0]        diff_w;
    logic                           ge_a;
    logic                           ge_w;

    // window length as used: zero acts as one
    assign eff_len   = (win_len_reg == '0) ? frm_pkg::LEN_W'(1) : win_len_reg;
    assign len_m1    = eff_len - frm_pkg::LEN_W'(1);
    assign pos_eff   = (ring_pos_reg >= eff_len) ? '0 : ring_pos_reg;
    assign pos_plus  = ring_pos_reg + frm_pkg::POS_W'(1);
    assign pos_next  = (pos_plus == eff_len) ? '0 : pos_plus;
    assign step_last = (step_cnt_reg == frm_pkg::STEP_W'(frm_pkg::STEPS - 1));

    // ring update for the item in the read cycle
    assign wr_bit    = primed_reg ? unique_reg : 1'b1;
    assign old_bit   = ring_valid_reg[ring_pos_reg] & rd_bit_reg;
    assign sum_next  = ring_sum_reg - frm_pkg::SUM_W'(old_bit) + frm_pkg::SUM_W'(wr_bit);

    // saturating time and counters
    assign time_sum  = {1'b0, time_acc_reg} + (frm_pkg::ELAPSED_W+1)'(period_reg);
    assign time_next = time_sum[frm_pkg::ELAPSED_W] ? '1 : time_sum[frm_pkg::ELAPSED_W-1:0];
    assign unique_next = (unique_reg && unique_total_reg != '1)
                       ? unique_total_reg + frm_pkg::COUNT_W'(1) : unique_total_reg;
    assign frames_next = (frames_seen_reg != '1)
                       ? frames_seen_reg + frm_pkg::COUNT_W'(1) : frames_seen_reg;

    // duplicate run clamped to the window
    assign run      = (dupe_run_reg > len_m1) ? len_m1 : dupe_run_reg;
    assign run_plus = run + frm_pkg::LEN_W'(1);

    // divider set-up: rounding offset of half the divisor
    assign num_a    = {1'b0, acc_a_reg} + frm_pkg::NUM_W'(den_a_reg[frm_pkg::DEN_W-1:1]);
    assign win_prod = {frm_pkg::LEN_W'(0), ring_sum_reg} * {frm_pkg::SUM_W'(0), eff_len};
    assign win_base = k_lt_len_reg ? win_prod : $bits(win_base)'(ring_sum_reg);
    assign den_w    = k_lt_len_reg ? den_a_reg : frm_pkg::DEN_W'(1);
    assign num_w    = frm_pkg::NUM_W'({win_base, 8'd0})
                    + frm_pkg::NUM_W'(den_w[frm_pkg::DEN_W-1:1]);

    // one restoring division step per divider
    assign r2_a   = {rem_a_reg, low_a_reg[frm_pkg::FPS_W-1]};
    assign r2_w   = {rem_w_reg, low_w_reg[frm_pkg::FPS_W-1]};
    assign ge_a   = (r2_a >= {1'b0, den_a_reg});
    assign ge_w   = (r2_w >= {1'b0, den_w_reg});
    assign diff_a = r2_a - {1'b0, den_a_reg};
    assign diff_w = r2_w - {1'b0, den_w_reg};

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer next state and handshake
    always_comb
    begin
        state_next  = state_reg;
        frame_ready = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            frm_pkg::ST_IDLE:
            begin
                frame_ready = 1'b1;
                if (frame.valid)
                begin
                    state_next = frm_pkg::ST_READ;
                end
            end
            frm_pkg::ST_READ:
            begin
                state_next = primed_reg ? frm_pkg::ST_MUL : frm_pkg::ST_IDLE;
            end
            frm_pkg::ST_MUL:
            begin
                if (step_last)
                begin
                    state_next = frm_pkg::ST_PREP;
                end
            end
            frm_pkg::ST_PREP:
            begin
                state_next = frm_pkg::ST_DIV;
            end
            frm_pkg::ST_DIV:
            begin
                if (step_last)
                begin
                    state_next = frm_pkg::ST_DONE;
                end
            end
            frm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = frm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frm_pkg::ST_IDLE;
            end
        endcase
    end

    assign frame.ready = frame_ready;
    assign accept      = frame.valid && frame_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= frm_pkg::WINDOW_LEN_RST;
            fps_reg     <= frm_pkg::FPS_RST;
            period_reg  <= frm_pkg::PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                frm_pkg::REG_WINDOW_LEN:   win_len_reg <= cfg_data[frm_pkg::LEN_W-1:0];
                frm_pkg::REG_RECORDED_FPS: fps_reg     <= cfg_data[frm_pkg::FPS_W-1:0];
                frm_pkg::REG_FRAME_PERIOD: period_reg  <= cfg_data[frm_pkg::PERIOD_W-1:0];
                default:                   ;
            endcase
        end
    end

    // ring memory: read on acceptance, write in the read cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_bit_reg <= ring_mem[pos_eff];
        end
        if (state_reg == frm_pkg::ST_READ)
        begin
            ring_mem[ring_pos_reg] <= wr_bit;
        end
    end

    // ring valid bits, sum and position; window length write clears them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_valid_reg <= '0;
            ring_sum_reg   <= '0;
            ring_pos_reg   <= '0;
        end
        else if (cfg_we && cfg_index == frm_pkg::REG_WINDOW_LEN)
        begin
            ring_valid_reg <= '0;
            ring_sum_reg   <= '0;
            ring_pos_reg   <= '0;
        end
        else if (accept)
        begin
            ring_pos_reg <= pos_eff;
        end
        else if (state_reg == frm_pkg::ST_READ)
        begin
            ring_valid_reg[ring_pos_reg] <= 1'b1;
            ring_sum_reg                 <= sum_next;
            ring_pos_reg                 <= pos_next;
        end
    end

    // counters, run length, time and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg       <= 1'b0;
            dupe_run_reg     <= '0;
            unique_total_reg <= '0;
            frames_seen_reg  <= '0;
            time_acc_reg     <= '0;
            step_cnt_reg     <= '0;
        end
        else
        begin
            if (state_reg == frm_pkg::ST_READ)
            begin
                time_acc_reg <= time_next;
                step_cnt_reg <= '0;
                if (!primed_reg)
                begin
                    primed_reg       <= 1'b1;
                    unique_total_reg <= frm_pkg::COUNT_W'(1);
                    frames_seen_reg  <= frm_pkg::COUNT_W'(1);
                    dupe_run_reg     <= '0;
                end
                else
                begin
                    unique_total_reg <= unique_next;
                    frames_seen_reg  <= frames_next;
                    if (unique_reg)
                    begin
                        dupe_run_reg <= '0;
                    end
                    else
                    begin
                        dupe_run_reg <= (run_plus > len_m1) ? len_m1 : run_plus;
                    end
                end
            end
            else if (state_reg == frm_pkg::ST_PREP)
            begin
                step_cnt_reg <= '0;
            end
            else if (state_reg == frm_pkg::ST_MUL || state_reg == frm_pkg::ST_DIV)
            begin
                step_cnt_reg <= step_cnt_reg + frm_pkg::STEP_W'(1);
            end
        end
    end

    // item datapath: shift-add multipliers and restoring dividers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            unique_reg <= frame.frame_unique;
        end
        unique case (state_reg)
            frm_pkg::ST_READ:
            begin
                den_a_reg    <= {1'b0, frames_seen_reg} + frm_pkg::DEN_W'(1);
                k_lt_len_reg <= (frames_seen_reg < frm_pkg::COUNT_W'(eff_len));
                mul_a_reg    <= frm_pkg::PROD_W'(unique_next);
                mul_b_reg    <= fps_reg;
                acc_a_reg    <= '0;
                ft_a_reg     <= frm_pkg::FT_W'(period_reg);
                ft_b_reg     <= unique_reg ? run_plus : '0;
                ft_acc_reg   <= '0;
            end
            frm_pkg::ST_MUL:
            begin
                if (mul_b_reg[0])
                begin
                    acc_a_reg <= acc_a_reg + mul_a_reg;
                end
                if (ft_b_reg[0])
                begin
                    ft_acc_reg <= ft_acc_reg + ft_a_reg;
                end
                mul_a_reg <= mul_a_reg << 1;
                mul_b_reg <= mul_b_reg >> 1;
                ft_a_reg  <= ft_a_reg << 1;
                ft_b_reg  <= ft_b_reg >> 1;
            end
            frm_pkg::ST_PREP:
            begin
                rem_a_reg <= num_a[frm_pkg::NUM_W-1:frm_pkg::FPS_W];
                low_a_reg <= num_a[frm_pkg::FPS_W-1:0];
                sat_a_reg <= (num_a[frm_pkg::NUM_W-1:frm_pkg::FPS_W] >= den_a_reg);
                rem_w_reg <= num_w[frm_pkg::NUM_W-1:frm_pkg::FPS_W];
                low_w_reg <= num_w[frm_pkg::FPS_W-1:0];
                sat_w_reg <= (num_w[frm_pkg::NUM_W-1:frm_pkg::FPS_W] >= den_w);
                den_w_reg <= den_w;
            end
            frm_pkg::ST_DIV:
            begin
                rem_a_reg <= ge_a ? diff_a[frm_pkg::DEN_W-1:0] : r2_a[frm_pkg::DEN_W-1:0];
                rem_w_reg <= ge_w ? diff_w[frm_pkg::DEN_W-1:0] : r2_w[frm_pkg::DEN_W-1:0];
                low_a_reg <= low_a_reg << 1;
                low_w_reg <= low_w_reg << 1;
                q_a_reg   <= {q_a_reg[frm_pkg::FPS_W-2:0], ge_a};
                q_w_reg   <= {q_w_reg[frm_pkg::FPS_W-2:0], ge_w};
            end
            default:
            begin
            end
        endcase
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            elapsed_reg   <= time_acc_reg;
            avg_fps_reg   <= sat_a_reg ? '1 : q_a_reg;
            win_fps_reg   <= sat_w_reg ? '1 : q_w_reg;
            frametime_reg <= ft_acc_reg;
            is_unique_reg <= unique_reg;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.elapsed_ns     = elapsed_reg;
    assign result.average_fps_q8 = avg_fps_reg;
    assign result.window_fps_q8  = win_fps_reg;
    assign result.frametime_ns   = frametime_reg;
    assign result.is_unique      = is_unique_reg;

`ifndef ASSERT_OFF
    // a result only appears after a finished division
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == frm_pkg::ST_DONE))
        else $error("result raised without a finished item");

    // reference frame and frame count go together
    a_primed_count: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg == (frames_seen_reg != '0))
        else $error("primed flag and frame count disagree");

    // the window sum never exceeds the window length
    a_sum_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        ring_sum_reg <= frm_pkg::SUM_W'(eff_len))
        else $error("ring sum above window length");

    // partial remainders stay below the divisor
    a_rem_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frm_pkg::ST_DIV && !sat_a_reg) |-> rem_a_reg < den_a_reg)
        else $error("average divider remainder out of range");

    a_rem_win: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frm_pkg::ST_DIV && !sat_w_reg) |-> rem_w_reg < den_w_reg)
        else $error("window divider remainder out of range");
`endif

endmodule

// ===== dv/frm_result_checker.sv =====
`timescale 1ns / 1ps
// frm_result_checker: tracks the meter state, predicts each result item and compares it
module frm_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    frm_in_if                              frame,
    frm_out_if                             result,
    input  logic                           cfg_we,
    input  logic [frm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [frm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                    fail_count,
    output int unsigned                    pending
);

    localparam longint unsigned ELAPSED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned FPS_MAX     = 64'd65535;

    typedef struct packed {
        logic [frm_pkg::ELAPSED_W-1:0] elapsed_ns;
        logic [frm_pkg::FPS_W-1:0]     average_fps_q8;
        logic [frm_pkg::FPS_W-1:0]     window_fps_q8;
        logic [frm_pkg::FT_W-1:0]      frametime_ns;
        logic                          is_unique;
    } frame_result_t;

    // meter state
    bit                           flag_ring [frm_pkg::MAX_WINDOW];
    int unsigned                  ring_sum;
    int unsigned                  ring_pos;
    int unsigned                  dupe_run;
    bit [frm_pkg::COUNT_W-1:0]    unique_total;
    bit [frm_pkg::COUNT_W-1:0]    frames_seen;
    longint unsigned              time_acc;
    bit                           primed;

    // register copies
    bit [frm_pkg::LEN_W-1:0]      window_len;
    bit [frm_pkg::FPS_W-1:0]      recorded_fps;
    bit [frm_pkg::PERIOD_W-1:0]   frame_period;

    frame_result_t                expected_results [$];
    int unsigned                  errors = 0;

    // division with round half up, clipped to the fps range
    function automatic longint unsigned rounded_fps(input longint unsigned num,
                                                    input longint unsigned den);
        longint unsigned q;
        q = (num + den / 2) / den;
        return (q > FPS_MAX) ? FPS_MAX : q;
    endfunction

    function automatic void clear_window();
        foreach (flag_ring[i])
            flag_ring[i] = 1'b0;
        ring_sum = 0;
        ring_pos = 0;
    endfunction

    // elapsed time grows by one period, saturating at the top of 63 bits
    function automatic void add_frame_time();
        longint unsigned p;
        p = frame_period;
        time_acc = (time_acc > ELAPSED_MAX - p) ? ELAPSED_MAX : time_acc + p;
    endfunction

    function automatic void reset_meter();
        clear_window();
        dupe_run     = 0;
        unique_total = '0;
        frames_seen  = '0;
        time_acc     = 0;
        primed       = 1'b0;
        window_len   = frm_pkg::WINDOW_LEN_RST;
        recorded_fps = frm_pkg::FPS_RST;
        frame_period = frm_pkg::PERIOD_RST;
    endfunction

    // advance the meter by one frame; returns 1 when the frame gives a result item
    function automatic bit next_frame_result(input logic uniq, output frame_result_t res);
        int unsigned     len;
        int unsigned     run;
        longint unsigned den;
        longint unsigned window_q;
        longint unsigned average_q;
        longint unsigned frametime;
        res = '0;
        len = (window_len == 0) ? 1 : window_len;
        if (ring_pos >= len)
            ring_pos = 0;

        // reference frame: always counted as unique, no result
        if (!primed)
        begin
            primed       = 1'b1;
            unique_total = 1;
            ring_sum     = ring_sum - flag_ring[ring_pos] + 1;
            flag_ring[ring_pos] = 1'b1;
            ring_pos     = (ring_pos + 1) % len;
            dupe_run     = 0;
            frames_seen  = 1;
            add_frame_time();
            return 1'b0;
        end

        den = 64'(frames_seen) + 1;
        if (uniq && unique_total != '1)
            unique_total++;

        ring_sum = ring_sum - flag_ring[ring_pos] + uniq;
        flag_ring[ring_pos] = uniq;

        // scaled up while the window is still filling
        if (frames_seen < len)
            window_q = rounded_fps(64'(ring_sum) * 256 * len, den);
        else
        begin
            window_q = 64'(ring_sum) * 256;
            if (window_q > FPS_MAX)
                window_q = FPS_MAX;
        end

        // duplicate run held below the window length
        run = (dupe_run > len - 1) ? len - 1 : dupe_run;
        if (uniq)
        begin
            frametime = 64'(run + 1) * frame_period;
            dupe_run  = 0;
        end
        else
        begin
            frametime = 0;
            dupe_run  = (run + 1 > len - 1) ? len - 1 : run + 1;
        end

        add_frame_time();
        average_q = rounded_fps(64'(unique_total) * recorded_fps, den);

        ring_pos = (ring_pos + 1) % len;
        if (frames_seen != '1)
            frames_seen++;

        res.elapsed_ns     = time_acc[frm_pkg::ELAPSED_W-1:0];
        res.average_fps_q8 = average_q[frm_pkg::FPS_W-1:0];
        res.window_fps_q8  = window_q[frm_pkg::FPS_W-1:0];
        res.frametime_ns   = frametime[frm_pkg::FT_W-1:0];
        res.is_unique      = uniq;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // follow register writes, predict on each frame item, compare each result item
    always @(posedge clk or negedge rst_n)
    begin : track
        frame_result_t want;
        frame_result_t got;
        if (!rst_n)
        begin
            reset_meter();
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    frm_pkg::REG_WINDOW_LEN:
                    begin
                        window_len = cfg_data[frm_pkg::LEN_W-1:0];
                        clear_window();
                    end
                    frm_pkg::REG_RECORDED_FPS: recorded_fps = cfg_data[frm_pkg::FPS_W-1:0];
                    frm_pkg::REG_FRAME_PERIOD: frame_period = cfg_data[frm_pkg::PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                got.elapsed_ns     = result.elapsed_ns;
                got.average_fps_q8 = result.average_fps_q8;
                got.window_fps_q8  = result.window_fps_q8;
                got.frametime_ns   = result.frametime_ns;
                got.is_unique      = result.is_unique;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $error("result item with no frame awaiting it");
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("elapsed_ns", 64'(want.elapsed_ns), 64'(got.elapsed_ns));
                    check_field("average_fps_q8", 64'(want.average_fps_q8),
                                64'(got.average_fps_q8));
                    check_field("window_fps_q8", 64'(want.window_fps_q8),
                                64'(got.window_fps_q8));
                    check_field("frametime_ns", 64'(want.frametime_ns),
                                64'(got.frametime_ns));
                    check_field("is_unique", 64'(want.is_unique), 64'(got.is_unique));
                end
            end

            if (frame.valid && frame.ready)
            begin
                if (next_frame_result(frame.frame_unique, want))
                    expected_results.insert(expected_results.size(), want);
            end
        end
        fail_count <= errors;
        pending    <= expected_results.size();
    end

endmodule

// ===== dv/tb_frame_rate_meter.sv =====
`timescale 1ns / 1ps
// tb_frame_rate_meter: clock, reset, frame stimulus, register phases and verdict
module tb_frame_rate_meter;

    localparam int CLK_PERIOD      = 4;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_AT     = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    // extra wait after the last expected result item has been taken
    localparam int SETTLE_CYCLES   = 40;
    localparam logic [frm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // reference frame first, then mixed unique and duplicate runs
    localparam logic [23:0] DIRECTED_FLAGS = 24'b0110_0010_1100_0000_1010_0111;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [frm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [frm_pkg::CFG_DATA_W-1:0] cfg_data;
    int unsigned                    fail_count;
    int unsigned                    pending;
    int unsigned                    quiet_cycles = 0;
    bit                             calm = 1'b0;

    frm_in_if  frame_ch ();
    frm_out_if result_ch ();

    frame_rate_meter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_ch.sink),
        .result    (result_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frm_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame_ch),
        .result     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** frame_rate_meter: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin : receiver
        int unsigned stall_left;
        int unsigned roll;
        int unsigned results_taken;
        bit          held_off;
        stall_left      = 0;
        results_taken   = 0;
        held_off        = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                results_taken++;
            if (!held_off && results_taken >= HOLD_OFF_AT)
            begin
                held_off   = 1'b1;
                stall_left = HOLD_OFF_CYCLES;
            end
            else if (stall_left == 0 && !calm)
            begin
                roll = $urandom_range(0, 99);
                if (roll >= 97)
                    stall_left = $urandom_range(30, 100);
                else if (roll >= 85)
                    stall_left = $urandom_range(4, 15);
                else if (roll >= 65)
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // gap before a frame item: mostly none, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // offer one frame item and wait until it is taken
    task automatic send_frame(input logic uniq);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid        <= 1'b1;
        frame_ch.frame_unique <= uniq;
        do
            @(posedge clk);
        while (!frame_ch.ready);
    endtask

    task automatic send_random_frames(input int unsigned count, input int unsigned unique_pct);
        repeat (count)
            send_frame($urandom_range(0, 99) < unique_pct);
    endtask

    // stop offering and let every outstanding result item drain
    task automatic settle();
        frame_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [frm_pkg::CFG_IDX_W-1:0] index,
                             input logic [frm_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_meter(input logic [frm_pkg::LEN_W-1:0] window_len,
                             input logic [frm_pkg::FPS_W-1:0] fps_q8,
                             input logic [frm_pkg::PERIOD_W-1:0] period_ns);
        write_reg(frm_pkg::REG_WINDOW_LEN, frm_pkg::CFG_DATA_W'(window_len));
        write_reg(frm_pkg::REG_RECORDED_FPS, frm_pkg::CFG_DATA_W'(fps_q8));
        write_reg(frm_pkg::REG_FRAME_PERIOD, frm_pkg::CFG_DATA_W'(period_ns));
    endtask

    initial
    begin : stimulus
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = frm_pkg::REG_WINDOW_LEN;
        cfg_data              = '0;
        frame_ch.valid        = 1'b0;
        frame_ch.frame_unique = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: directed frames, then past the warm-up of 60
        for (int i = 23; i >= 0; i--)
            send_frame(DIRECTED_FLAGS[i]);
        send_random_frames(60, 50);
        settle();

        // single-frame window, top frame rate, zero period
        set_meter(8'd1, 16'hFFFF, 30'd0);
        send_random_frames(30, 50);
        settle();

        // zero window behaves as one, zero frame rate; no idling on either side
        calm <= 1'b1;
        set_meter(8'd0, 16'd0, 30'd1);
        send_random_frames(30, 50);
        settle();
        calm <= 1'b0;

        // longest window, warm-up scaling in use while the window fills
        set_meter(8'd255, 16'hFFFF, 30'd1_000_000_000);
        send_random_frames(110, 70);
        settle();

        // two-frame window, widest period
        set_meter(8'd2, 16'd1, 30'h3FFF_FFFF);
        send_random_frames(50, 30);
        settle();

        // back to reset values, mostly duplicates for long duplicate runs
        set_meter(frm_pkg::WINDOW_LEN_RST, frm_pkg::FPS_RST, frm_pkg::PERIOD_RST);
        send_random_frames(130, 10);
        settle();

        // random settings; a write to the unused index changes nothing
        set_meter(8'd7, frm_pkg::FPS_W'($urandom_range(1, 65535)),
                  frm_pkg::PERIOD_W'($urandom_range(1, 1_000_000_000)));
        write_reg(REG_SPARE, frm_pkg::CFG_DATA_W'($urandom));
        send_random_frames(60, 50);
        settle();

        // frame rate alone changed, window contents kept
        write_reg(frm_pkg::REG_RECORDED_FPS, frm_pkg::CFG_DATA_W'($urandom_range(1, 65535)));
        send_random_frames(60, 95);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("** frame_rate_meter: PASSED **");
        else
            $display("** frame_rate_meter: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/frm_pkg.sv
hw/rtl/frm_if.sv
hw/rtl/frame_rate_meter.sv
dv/frm_result_checker.sv
dv/tb_frame_rate_meter.sv
